// ===== design/vas_pkg.sv =====
// Shared types and constants of the voice allocator.
package vas_pkg;

    localparam int PADDR_W       = 3;
    localparam int DATA_W        = 32;
    localparam int POLY_W        = 5;
    localparam int STAMP_W       = 64;
    localparam int VIDX_W        = 6;
    localparam int PAD_FIELD_W   = 8;
    localparam int PAD_MAX_W     = 16;
    localparam int VOICE_FIELD_W = 4;
    localparam int MASK_W        = 16;

    // Word index of the polyphony register on the configuration port.
    localparam logic REG_POLYPHONY = 1'b0;

    typedef enum logic [1:0] {
        OP_NOTE_ON    = 2'd0,
        OP_NOTE_OFF   = 2'd1,
        OP_VOICE_DONE = 2'd2,
        OP_ALL_OFF    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_RETRIGGER = 2'd0,
        KIND_FREE      = 2'd1,
        KIND_STEAL     = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_RESP = 2'd2
    } state_t;

    typedef logic [PAD_FIELD_W-1:0]   pad_field_t;
    typedef logic [VOICE_FIELD_W-1:0] voice_field_t;
    typedef logic [MASK_W-1:0]        mask_t;

    // Running scan record that travels down the row of voice cells.
    typedef struct packed {
        logic               valid;
        logic               match_found;
        logic [VIDX_W-1:0]  match_idx;
        logic               free_found;
        logic [VIDX_W-1:0]  free_idx;
        logic               old_found;
        logic [VIDX_W-1:0]  old_idx;
        logic [STAMP_W-1:0] old_stamp;
    } scan_rec_t;

    // Per-cell update strobes from the controller.
    typedef struct packed {
        logic start;
        logic clear;
    } cell_ctl_t;

endpackage

// ===== design/vas_ifs.sv =====
// Command and result channel interfaces of the voice allocator.
interface vas_cmd_if;
    logic                  valid;
    logic                  ready;
    vas_pkg::opcode_t      opcode;
    vas_pkg::pad_field_t   pad_index;
    logic                  pad_playable;
    vas_pkg::voice_field_t voice_index;

    modport source (
        output valid, opcode, pad_index, pad_playable, voice_index,
        input  ready
    );
    modport sink (
        input  valid, opcode, pad_index, pad_playable, voice_index,
        output ready
    );
endinterface

interface vas_res_if;
    logic                  valid;
    logic                  ready;
    logic                  start_valid;
    vas_pkg::voice_field_t start_voice;
    vas_pkg::kind_t        start_kind;
    vas_pkg::mask_t        release_mask;

    modport source (
        output valid, start_valid, start_voice, start_kind, release_mask,
        input  ready
    );
    modport sink (
        input  valid, start_valid, start_voice, start_kind, release_mask,
        output ready
    );
endinterface

// ===== design/vas_cell.sv =====
// One voice slot of the allocator row, with its stage of the scan chain.
module vas_cell #(
    parameter int CELL_IDX = 0,
    parameter int PAD_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [vas_pkg::POLY_W-1:0]    polyphony,
    input  logic [PAD_BITS-1:0]           scan_pad,
    input  logic [PAD_BITS-1:0]           probe_pad,
    input  logic [vas_pkg::STAMP_W-1:0]   stamp_in,
    input  vas_pkg::cell_ctl_t            ctl,
    input  vas_pkg::scan_rec_t            rec_in,
    output vas_pkg::scan_rec_t            rec_out,
    output logic                          hit
);
    import vas_pkg::*;

    localparam logic [VIDX_W-1:0] MY_IDX = VIDX_W'(CELL_IDX);

    logic                active_reg, active_next;
    logic [PAD_BITS-1:0] pad_reg, pad_next;
    logic [STAMP_W-1:0]  stamp_reg, stamp_next;
    scan_rec_t           rec_reg, rec_next;
    logic                in_range;
    logic                scan_hit;

    assign in_range = (CELL_IDX < int'(polyphony));
    assign scan_hit = active_reg && (pad_reg == scan_pad);
    assign hit      = active_reg && (pad_reg == probe_pad);
    assign rec_out  = rec_reg;

    always_comb
    begin
        rec_next = rec_in;
        if (in_range)
        begin
            if (!rec_in.match_found && scan_hit)
            begin
                rec_next.match_found = 1'b1;
                rec_next.match_idx   = MY_IDX;
            end
            if (!rec_in.free_found && !active_reg)
            begin
                rec_next.free_found = 1'b1;
                rec_next.free_idx   = MY_IDX;
            end
            // Strict compare keeps the lower index on equal stamps.
            if (active_reg && (!rec_in.old_found || (stamp_reg < rec_in.old_stamp)))
            begin
                rec_next.old_found = 1'b1;
                rec_next.old_idx   = MY_IDX;
                rec_next.old_stamp = stamp_reg;
            end
        end
    end

    always_comb
    begin
        active_next = active_reg;
        pad_next    = pad_reg;
        stamp_next  = stamp_reg;
        if (ctl.clear)
        begin
            active_next = 1'b0;
        end
        if (ctl.start)
        begin
            active_next = 1'b1;
            pad_next    = scan_pad;
            stamp_next  = stamp_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pad_reg    <= '0;
            stamp_reg  <= '0;
            rec_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            pad_reg    <= pad_next;
            stamp_reg  <= stamp_next;
            rec_reg    <= rec_next;
        end
    end

endmodule

// ===== design/voice_allocator_oldest_steal_unit.sv =====
// Top level of the voice allocator: controller, configuration port and the voice cell row.
//
//   channel   kind        direction  fields
//   cmd       valid/ready in         opcode, pad_index, pad_playable, voice_index
//   res       valid/ready out        start_valid, start_voice, start_kind, release_mask
//   apb       psel/penable in/out    polyphony register at byte address 0
//
// A playable note-on walks its scan record down the row of voice cells, one cell per cycle,
// and its result passes through the pending and output registers once the record leaves the
// last cell; every other command goes straight to those registers. A new command is taken
// once the previous result is in the output register, even while it still waits on res.
// Reset clears every voice, the stamp counter and sets polyphony to its default.
// A stalled result holds the block only once a second result is ready to be registered.
module voice_allocator_oldest_steal_unit #(
    parameter int MAX_VOICES = 16,
    parameter int PAD_BITS   = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vas_pkg::PADDR_W-1:0]   paddr,
    input  logic [vas_pkg::DATA_W-1:0]    pwdata,
    output logic [vas_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    vas_cmd_if.sink                       cmd,
    vas_res_if.source                     res
);
    import vas_pkg::*;

    localparam logic [POLY_W-1:0] POLY_RESET =
        (MAX_VOICES < 16) ? POLY_W'(MAX_VOICES) : POLY_W'(16);

    // Controller state.
    state_t               state_reg, state_next;
    logic                 launch_reg, launch_next;
    logic [PAD_BITS-1:0]  cmd_pad_reg, cmd_pad_next;
    logic [STAMP_W-1:0]   stamp_cnt_reg, stamp_cnt_next;
    logic [POLY_W-1:0]    poly_reg, poly_next;

    // Pending result, waiting for the output register.
    logic                 pend_start_reg, pend_start_next;
    voice_field_t         pend_voice_reg, pend_voice_next;
    kind_t                pend_kind_reg, pend_kind_next;
    mask_t                pend_mask_reg, pend_mask_next;

    // Output register.
    logic                 res_valid_reg, res_valid_next;
    logic                 res_start_reg, res_start_next;
    voice_field_t         res_voice_reg, res_voice_next;
    kind_t                res_kind_reg, res_kind_next;
    mask_t                res_mask_reg, res_mask_next;

    // Cell row.
    scan_rec_t            rec [MAX_VOICES+1];
    cell_ctl_t            ctl [MAX_VOICES];
    logic [MAX_VOICES-1:0] hit_vec;
    logic [MAX_VOICES-1:0] start_vec;
    logic [MAX_VOICES+MASK_W-1:0] hit_wide;
    logic [PAD_MAX_W-1:0] pad_wide;
    logic [PAD_BITS-1:0]  pad_eff;
    scan_rec_t            chain_out;

    logic                 cmd_fire;
    logic                 is_scan;
    logic                 out_free;
    logic                 cfg_write;
    logic [POLY_W-1:0]    wr_poly;
    logic [VIDX_W-1:0]    chosen_idx;
    kind_t                chosen_kind;

    // Configuration port: zero wait states, one register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_POLYPHONY);
    assign prdata    = (paddr[2] == REG_POLYPHONY) ? DATA_W'(poly_reg) : '0;

    // A written polyphony is clamped to one through MAX_VOICES.
    always_comb
    begin
        wr_poly = pwdata[POLY_W-1:0];
        if (wr_poly == '0)
        begin
            wr_poly = POLY_W'(1);
        end
        else if (int'(wr_poly) > MAX_VOICES)
        begin
            wr_poly = POLY_W'(MAX_VOICES);
        end
        poly_next = cfg_write ? wr_poly : poly_reg;
    end

    // The pad number is cut or zero-extended to PAD_BITS.
    assign pad_wide = PAD_MAX_W'(cmd.pad_index);
    assign pad_eff  = pad_wide[PAD_BITS-1:0];

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign is_scan   = (cmd.opcode == OP_NOTE_ON) && cmd.pad_playable;
    assign out_free  = !res_valid_reg || res.ready;

    // The scan record enters the first cell as an empty token.
    always_comb
    begin
        rec[0]       = '0;
        rec[0].valid = launch_reg;
    end

    assign chain_out = rec[MAX_VOICES];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_VOICES; gi++)
        begin : g_cell
            vas_cell #(
                .CELL_IDX (gi),
                .PAD_BITS (PAD_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .polyphony (poly_reg),
                .scan_pad  (cmd_pad_reg),
                .probe_pad (pad_eff),
                .stamp_in  (stamp_cnt_reg),
                .ctl       (ctl[gi]),
                .rec_in    (rec[gi]),
                .rec_out   (rec[gi+1]),
                .hit       (hit_vec[gi])
            );
            assign start_vec[gi] = ctl[gi].start;
        end
    endgenerate

    // Only the first sixteen voices are shown in the release mask.
    assign hit_wide = (MAX_VOICES+MASK_W)'(hit_vec);

    // Priority at the end of the row: same pad, then lowest free, then oldest.
    always_comb
    begin
        if (chain_out.match_found)
        begin
            chosen_idx  = chain_out.match_idx;
            chosen_kind = KIND_RETRIGGER;
        end
        else if (chain_out.free_found)
        begin
            chosen_idx  = chain_out.free_idx;
            chosen_kind = KIND_FREE;
        end
        else
        begin
            chosen_idx  = chain_out.old_idx;
            chosen_kind = KIND_STEAL;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = is_scan ? ST_SCAN : ST_RESP;
                end
            end
            ST_SCAN:
            begin
                if (chain_out.valid)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller outputs and datapath updates.
    always_comb
    begin
        launch_next     = 1'b0;
        cmd_pad_next    = cmd_pad_reg;
        stamp_cnt_next  = stamp_cnt_reg;
        pend_start_next = pend_start_reg;
        pend_voice_next = pend_voice_reg;
        pend_kind_next  = pend_kind_reg;
        pend_mask_next  = pend_mask_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_start_next  = res_start_reg;
        res_voice_next  = res_voice_reg;
        res_kind_next   = res_kind_reg;
        res_mask_next   = res_mask_reg;
        for (int k = 0; k < MAX_VOICES; k++)
        begin
            ctl[k] = '0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    launch_next     = is_scan;
                    cmd_pad_next    = pad_eff;
                    pend_start_next = 1'b0;
                    pend_voice_next = '0;
                    pend_kind_next  = KIND_RETRIGGER;
                    pend_mask_next  = (cmd.opcode == OP_NOTE_OFF) ? hit_wide[MASK_W-1:0]
                                                                  : '0;
                    for (int k = 0; k < MAX_VOICES; k++)
                    begin
                        ctl[k].clear = (cmd.opcode == OP_ALL_OFF) ||
                                       ((cmd.opcode == OP_VOICE_DONE) &&
                                        (int'(cmd.voice_index) == k));
                    end
                end
            end
            ST_SCAN:
            begin
                if (chain_out.valid)
                begin
                    for (int k = 0; k < MAX_VOICES; k++)
                    begin
                        ctl[k].start = (chosen_idx == VIDX_W'(k));
                    end
                    stamp_cnt_next  = stamp_cnt_reg + STAMP_W'(1);
                    pend_start_next = 1'b1;
                    pend_voice_next = chosen_idx[VOICE_FIELD_W-1:0];
                    pend_kind_next  = chosen_kind;
                    pend_mask_next  = '0;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_start_next = pend_start_reg;
                    res_voice_next = pend_voice_reg;
                    res_kind_next  = pend_kind_reg;
                    res_mask_next  = pend_mask_reg;
                end
            end
            default:
            begin
                launch_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            stamp_cnt_reg <= '0;
            poly_reg      <= POLY_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            stamp_cnt_reg <= stamp_cnt_next;
            poly_reg      <= poly_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_pad_reg    <= cmd_pad_next;
        pend_start_reg <= pend_start_next;
        pend_voice_reg <= pend_voice_next;
        pend_kind_reg  <= pend_kind_next;
        pend_mask_reg  <= pend_mask_next;
        res_start_reg  <= res_start_next;
        res_voice_reg  <= res_voice_next;
        res_kind_reg   <= res_kind_next;
        res_mask_reg   <= res_mask_next;
    end

    assign res.valid        = res_valid_reg;
    assign res.start_valid  = res_start_reg;
    assign res.start_voice  = res_voice_reg;
    assign res.start_kind   = res_kind_reg;
    assign res.release_mask = res_mask_reg;

    // The scan token only reaches the end of the row while the controller waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.valid |-> (state_reg == ST_SCAN))
        else $error("scan token left the cell row outside of a scan");

    // A note-on starts at most one voice.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(start_vec))
        else $error("more than one voice started in one cycle");

    // A started voice and a release mask never come from the same command.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.start_valid) |-> (res.release_mask == '0))
        else $error("result carries both a start and a release mask");

    // The stamp counter moves only when a voice was started.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(stamp_cnt_reg) |-> $past(|start_vec))
        else $error("stamp counter advanced without a voice start");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the voice allocator with oldest-voice stealing.
module tb_top;
    import vas_pkg::*;

    localparam int VOICES      = 16;
    localparam int CLK_HALF    = 5;
    localparam int RESET_CYCLES = 12;
    // The settle margin is sized from the number of voices.
    localparam int SETTLE_CYCLES = VOICES + 8;
    localparam int PRINT_CAP   = 100;

    // One result of the allocator as it appears on the result channel.
    typedef struct packed {
        logic         start_valid;
        voice_field_t start_voice;
        kind_t        start_kind;
        mask_t        release_mask;
    } alloc_result_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    vas_cmd_if cmd_ch ();
    vas_res_if res_ch ();

    voice_allocator_oldest_steal_unit #(
        .MAX_VOICES (VOICES),
        .PAD_BITS   (8)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd_ch),
        .res     (res_ch)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the voice slots, the stamp
    // counter and the polyphony setting. It starts out as reset leaves
    // the block and is only touched at accepted transfers and register
    // writes, so it always mirrors the block once the pipeline drains.
    // ------------------------------------------------------------------
    logic             voice_busy [VOICES];
    pad_field_t       voice_pad_of [VOICES];
    logic [STAMP_W-1:0] voice_started_at [VOICES];
    logic [STAMP_W-1:0] stamp_count;
    int               poly_limit;

    // Results predicted for accepted commands, oldest first.
    alloc_result_t    pending_results[$];
    int               error_count;
    int               printed_errors;
    // When set, both sides of the traffic insert random idle bursts.
    bit               idle_on;

    initial
    begin
        for (int i = 0; i < VOICES; i++)
        begin
            voice_busy[i]       = 1'b0;
            voice_pad_of[i]     = '0;
            voice_started_at[i] = '0;
        end
        stamp_count    = '0;
        poly_limit     = 16;
        error_count    = 0;
        printed_errors = 0;
        idle_on        = 1'b1;
    end

    // Computes the result of one command and advances the slot state.
    // Note-on looks for a retrigger on the same pad first, then the lowest
    // free slot, and otherwise steals the active slot that started first.
    // Only the first poly_limit slots take part in a note-on; note-off
    // looks at every slot.
    function automatic alloc_result_t allocate_voice(opcode_t op, pad_field_t pad,
                                                     logic playable, voice_field_t vidx);
        alloc_result_t r;
        int            chosen;
        kind_t         kind;
        r      = '0;
        chosen = -1;
        kind   = KIND_RETRIGGER;
        case (op)
            OP_NOTE_ON:
            begin
                if (playable)
                begin
                    for (int i = 0; i < poly_limit; i++)
                        if (chosen < 0 && voice_busy[i] && voice_pad_of[i] == pad)
                        begin
                            chosen = i;
                            kind   = KIND_RETRIGGER;
                        end
                    for (int i = 0; i < poly_limit; i++)
                        if (chosen < 0 && !voice_busy[i])
                        begin
                            chosen = i;
                            kind   = KIND_FREE;
                        end
                    if (chosen < 0)
                    begin
                        // Every usable slot is active here, so the steal cannot fail.
                        // A strict comparison keeps the lowest index on equal stamps.
                        for (int i = 0; i < poly_limit; i++)
                            if (voice_busy[i] &&
                                (chosen < 0 || voice_started_at[i] < voice_started_at[chosen]))
                                chosen = i;
                        kind = KIND_STEAL;
                    end
                    voice_busy[chosen]       = 1'b1;
                    voice_pad_of[chosen]     = pad;
                    voice_started_at[chosen] = stamp_count;
                    stamp_count              = stamp_count + 1'b1;
                    r.start_valid = 1'b1;
                    r.start_voice = voice_field_t'(chosen);
                    r.start_kind  = kind;
                end
            end
            OP_NOTE_OFF:
            begin
                // Released voices keep playing, so the state is left alone.
                for (int i = 0; i < VOICES; i++)
                    if (voice_busy[i] && voice_pad_of[i] == pad)
                        r.release_mask[i] = 1'b1;
            end
            OP_VOICE_DONE:
            begin
                if (int'(vidx) < VOICES)
                    voice_busy[vidx] = 1'b0;
            end
            default:
            begin
                for (int i = 0; i < VOICES; i++)
                    voice_busy[i] = 1'b0;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, and the hard stop for a run that hangs.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // The limit lies far above the length of the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: the ready line is changed at falling edges and stalls
    // in short random bursts while idling is on.
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 3) - 1;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Every result transfer is matched against the oldest prediction.
    // Values are read right at the rising edge, before the block updates.
    // Results print as start/voice/kind/mask.
    initial
    begin
        alloc_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    if (printed_errors < PRINT_CAP)
                    begin
                        printed_errors++;
                        $display("%0t: result with none expected: %b/%0d/%0d/%h",
                                 $time, res_ch.start_valid, res_ch.start_voice,
                                 res_ch.start_kind, res_ch.release_mask);
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (res_ch.start_valid !== want.start_valid ||
                        res_ch.start_voice !== want.start_voice ||
                        res_ch.start_kind !== want.start_kind ||
                        res_ch.release_mask !== want.release_mask)
                    begin
                        error_count++;
                        if (printed_errors < PRINT_CAP)
                        begin
                            printed_errors++;
                            $display("%0t: mismatch: expected %b/%0d/%0d/%h got %b/%0d/%0d/%h",
                                     $time, want.start_valid, want.start_voice,
                                     want.start_kind, want.release_mask,
                                     res_ch.start_valid, res_ch.start_voice,
                                     res_ch.start_kind, res_ch.release_mask);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Command side.
    // ------------------------------------------------------------------

    // Offers one command and waits for its transfer. Valid is left high on
    // return so that the next command is offered without a gap in valid;
    // a random idle burst may come first while idling is on.
    task automatic send_event(opcode_t op, pad_field_t pad, logic playable, voice_field_t vidx);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            repeat (gap)
            begin
                @(negedge clk);
                cmd_ch.valid <= 1'b0;
            end
        end
        @(negedge clk);
        cmd_ch.valid        <= 1'b1;
        cmd_ch.opcode       <= op;
        cmd_ch.pad_index    <= pad;
        cmd_ch.pad_playable <= playable;
        cmd_ch.voice_index  <= vidx;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        pending_results.push_back(allocate_voice(op, pad, playable, vidx));
    endtask

    // Stops offering commands and waits until every result is back.
    // Every command yields a result, so the block is idle after a short
    // margin.
    task automatic drain_block();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes the polyphony register through a setup and an access cycle.
    // The block must be drained first. The predictor stores the clamped value.
    task automatic write_polyphony(logic [DATA_W-1:0] value);
        int p;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(REG_POLYPHONY) << 2;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        p = int'(value[POLY_W-1:0]);
        if (p < 1)
            p = 1;
        if (p > VOICES)
            p = VOICES;
        poly_limit = p;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One random command. Most pads come from a small pool a little larger
    // than the usable voices, so retriggers, note-offs that hit and steals
    // are all frequent; the rest span the whole pad range.
    task automatic send_random_event(int pad_pool);
        int         pick;
        opcode_t    op;
        pad_field_t pad;
        logic       playable;
        pick = $urandom_range(0, 99);
        if (pick < 52)
            op = OP_NOTE_ON;
        else if (pick < 77)
            op = OP_NOTE_OFF;
        else if (pick < 97)
            op = OP_VOICE_DONE;
        else
            op = OP_ALL_OFF;
        if ($urandom_range(0, 4) == 0)
            pad = pad_field_t'($urandom_range(0, 255));
        else
            pad = pad_field_t'($urandom_range(0, pad_pool - 1));
        playable = ($urandom_range(0, 9) != 0);
        send_event(op, pad, playable, voice_field_t'($urandom_range(0, VOICES - 1)));
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Hand-picked sequences: pad extremes, every command, retrigger, free
    // and steal choices, unplayable pads, voice-done on a free voice, and
    // voices left active above a lowered polyphony.
    task automatic test_directed_cases();
        // Reset polyphony of sixteen.
        send_event(OP_NOTE_ON,    8'h00, 1'b1, 4'd0);   // free slot 0
        send_event(OP_NOTE_ON,    8'hFF, 1'b1, 4'd15);  // free slot 1
        send_event(OP_NOTE_ON,    8'hFF, 1'b1, 4'd0);   // retrigger slot 1
        send_event(OP_NOTE_ON,    8'h07, 1'b0, 4'd0);   // unplayable: nothing happens
        send_event(OP_NOTE_OFF,   8'hFF, 1'b0, 4'd0);   // release slot 1, stays active
        send_event(OP_NOTE_OFF,   8'hFF, 1'b1, 4'd0);   // same mask again
        send_event(OP_VOICE_DONE, 8'h00, 1'b0, 4'd0);   // free slot 0
        send_event(OP_VOICE_DONE, 8'h00, 1'b0, 4'd0);   // slot 0 is already free
        send_event(OP_NOTE_ON,    8'h00, 1'b1, 4'd0);   // lowest free slot again
        send_event(OP_ALL_OFF,    8'hFF, 1'b1, 4'd15);
        send_event(OP_NOTE_OFF,   8'h00, 1'b1, 4'd0);   // nothing active
        drain_block();

        // Two voices: fill them, then steal in start order.
        write_polyphony(32'd2);
        send_event(OP_NOTE_ON, 8'h01, 1'b1, 4'd0);
        send_event(OP_NOTE_ON, 8'h02, 1'b1, 4'd0);
        send_event(OP_NOTE_ON, 8'h03, 1'b1, 4'd0);      // steals slot 0
        send_event(OP_NOTE_ON, 8'h04, 1'b1, 4'd0);      // steals slot 1
        send_event(OP_NOTE_ON, 8'h03, 1'b1, 4'd0);      // retrigger slot 0
        drain_block();

        // One voice: slot 1 stays active outside the usable range, so the
        // same pad ends up on two slots and note-off reports both.
        write_polyphony(32'd1);
        send_event(OP_NOTE_ON,    8'h04, 1'b1, 4'd0);   // steals slot 0
        send_event(OP_NOTE_OFF,   8'h04, 1'b1, 4'd0);
        send_event(OP_VOICE_DONE, 8'hAA, 1'b1, 4'd15);  // free voice stays free
        send_event(OP_VOICE_DONE, 8'h55, 1'b0, 4'd1);   // voice above polyphony
        send_event(OP_NOTE_OFF,   8'h04, 1'b0, 4'd0);
        send_event(OP_ALL_OFF,    8'h00, 1'b0, 4'd0);
        drain_block();
    endtask

    // Random traffic under a series of polyphony settings: the extremes,
    // values that get clamped on both sides, one with high data bits set
    // and a fully random word.
    task automatic test_polyphony_sweep();
        logic [DATA_W-1:0] settings[9];
        settings = '{32'd16, 32'd1, 32'd0, 32'd3, 32'd31,
                     32'd8, 32'd17, 32'hFFFF_FFE5, 32'(0)};
        settings[8] = $urandom;
        foreach (settings[s])
        begin
            write_polyphony(settings[s]);
            repeat (140)
                send_random_event(poly_limit + 3);
            drain_block();
        end
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_back_to_back_tail();
        write_polyphony(32'd12);
        idle_on = 1'b0;
        repeat (190)
            send_random_event(poly_limit + 3);
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.opcode       = OP_NOTE_ON;
        cmd_ch.pad_index    = '0;
        cmd_ch.pad_playable = 1'b0;
        cmd_ch.voice_index  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_cases();
        test_polyphony_sweep();
        test_back_to_back_tail();

        // Wait for the last results, then a little longer so that any
        // stray transfer would still be caught.
        drain_block();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
